// ----- hdl/rbgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_pkg: shared types and constants of the red-black pressure solver
// Command, status and register codes plus the payload structs of both channels.
// ----------------------------------------------------------------------------
package rbgs_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int SIZE_W    = 13;   // dimension size field width
  localparam int COORD_W   = 13;   // coordinate along one dimension
  localparam int DIV_W     = 38;   // dividend width of the rounding divider
  localparam int CNT_W     = 4;    // neighbor count 0..8
  localparam int SUM_W     = 36;   // sum of up to eight pressures
  localparam int RES_W     = 39;   // residual width
  localparam int CHECK_PERIOD = 10;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_TOO_BIG   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_SOLVE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_0    = 3'd1,
    REG_SIZE_1    = 3'd2,
    REG_SIZE_2    = 3'd3,
    REG_SIZE_3    = 3'd4,
    REG_ITER_LIM  = 3'd5,
    REG_TOL       = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        cell_index;
    logic signed [31:0] rhs_value;
    logic signed [31:0] initial_pressure;
    logic               is_obstacle;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] pressure_value;
    logic [15:0]        iterations_run;
    logic [1:0]         solve_status;
  } out_item_t;

endpackage

// ----- hdl/rbgs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_div: bit-serial unsigned divider
// Restoring division of a wide magnitude by a neighbor count, one bit a cycle.
// ----------------------------------------------------------------------------
module rbgs_div
  import rbgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  localparam int BW = $clog2(DIV_W + 1);

  logic [BW-1:0]    bits_r, bits_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] den_r, den_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;

  // one quotient bit per cycle; quotient shifts into the dividend register
  always_comb begin
    bits_nxt = bits_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[DIV_W-1]};
    if (go) begin
      bits_nxt = BW'(DIV_W);
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (bits_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, den_r});
        num_nxt = {num_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        num_nxt = {num_r[DIV_W-2:0], 1'b0};
      end
      bits_nxt = bits_r - BW'(1);
      done_nxt = (bits_r == BW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      done_r <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ----- hdl/red_black_gauss_seidel_pressure_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_black_gauss_seidel_pressure_top: red-black Gauss-Seidel pressure solver
// Poisson solve over a 1 to 4 dimensional grid of Q16.16 cells with obstacles.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_data when start is high and busy is low. A load
//   writes one cell in the transfer cycle and leaves busy low. A read holds
//   busy high through S_RD and S_RDOUT and strobes out_valid in S_RDOUT. A
//   solve keeps busy high for its whole run and ends with one report strobe
//   (iterations and status). Setup takes one multiply per dimension, twice;
//   each iteration then makes two sweeps over all cells, every tenth a third
//   residual sweep. A skipped cell passes S_SWEEP, S_CHK and S_NEXT; a visited
//   cell also tries all eight neighbor slots in S_NB with an S_NBACC step per
//   in-grid neighbor, then S_CALC and S_RES2 in a residual sweep or the shared
//   serial divider for an updated cell. The divider and the single memory
//   read port set the pace. Results are strobed for one cycle and cannot be
//   held off; out_valid shows each result exactly once. Configuration is
//   written on cfg_we with no wait; the user must write it only while idle,
//   which the block itself does not enforce. Reset returns the registers to
//   their defaults and the sequencer to idle; the cell memories are not
//   cleared and must be loaded before a solve.
// ----------------------------------------------------------------------------
module red_black_gauss_seidel_pressure_top
  import rbgs_pkg::*;
#(
  parameter int MAX_CELLS = 4096
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int TW = $clog2(MAX_CELLS + 1);
  localparam int PW = TW + SIZE_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_RD    = 14'b00000000000010,
    S_TOT   = 14'b00000000000100,
    S_STR   = 14'b00000000001000,
    S_SWEEP = 14'b00000000010000,
    S_CHK   = 14'b00000000100000,
    S_NB    = 14'b00000001000000,
    S_NBACC = 14'b00000010000000,
    S_CALC  = 14'b00000100000000,
    S_DIVW  = 14'b00001000000000,
    S_RES2  = 14'b00010000000000,
    S_NEXT  = 14'b00100000000000,
    S_REP   = 14'b01000000000000,
    S_RDOUT = 14'b10000000000000
  } state_t;

  // configuration registers
  logic [2:0]        ndim_r;
  logic [SIZE_W-1:0] size_r [MAX_DIMS];
  logic [15:0]       lim_r;
  logic [30:0]       tol_r;

  // cell memories
  logic signed [31:0] pmem [MAX_CELLS];
  logic signed [31:0] rmem [MAX_CELLS];
  logic               omem [MAX_CELLS];
  logic signed [31:0] p_q, r_q;
  logic               o_q;

  state_t state_r, state_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [TW-1:0]       st_r, st_nxt;
  logic [TW-1:0]       stride_r [MAX_DIMS];
  logic [TW-1:0]       stride_nxt [MAX_DIMS];
  logic [AW-1:0]       c_r, c_nxt;
  logic [COORD_W-1:0]  coord_r [MAX_DIMS];
  logic [COORD_W-1:0]  coord_nxt [MAX_DIMS];
  logic                color_r, color_nxt;
  logic                res_r, res_nxt;
  logic [15:0]         it_r, it_nxt;
  logic [3:0]          chk_r, chk_nxt;
  logic [2:0]          j_r, j_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic signed [31:0]  pc_r, pc_nxt;
  logic signed [31:0]  rc_r, rc_nxt;
  logic signed [36:0]  np_r, np_nxt;
  logic [RES_W-1:0]    worst_r, worst_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic                neg_r, neg_nxt;
  logic                ov_r, ov_nxt;
  out_item_t           od_r, od_nxt;

  // derived configuration
  logic [2:0]        nd_eff;
  logic [1:0]        nd_m1;
  logic [SIZE_W-1:0] sz [MAX_DIMS];

  // combinational helpers
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wp, wr;
  logic               wo;
  logic [31:0]        idx_ext;
  logic               idx_ok;
  logic [PW-1:0]      tot_prod, st_prod;
  logic               par;
  logic [1:0]         jd;
  logic               nb_ok;
  logic [AW-1:0]      nb_addr;
  logic signed [SUM_W:0] xv;
  logic [SUM_W:0]     xmag;
  logic [DIV_W-1:0]   dvd;
  logic               div_go, div_done;
  logic [DIV_W-1:0]   quo;
  logic signed [DIV_W:0] qs;
  logic signed [31:0] qsat;
  logic signed [RES_W-1:0] rv;
  logic [RES_W-1:0]   rmag;
  logic               carry;
  logic               last_cell;

  always_comb begin
    nd_eff = ndim_r;
    if (ndim_r == 3'd0) nd_eff = 3'd1;
    if (ndim_r > 3'(MAX_DIMS)) nd_eff = 3'(MAX_DIMS);
    nd_m1 = 2'(nd_eff - 3'd1);
    for (int d = 0; d < MAX_DIMS; d++) begin
      sz[d] = (size_r[d] == '0) ? SIZE_W'(1) : size_r[d];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndim_r    <= 3'd2;
      size_r[0] <= SIZE_W'(64);
      size_r[1] <= SIZE_W'(64);
      size_r[2] <= SIZE_W'(1);
      size_r[3] <= SIZE_W'(1);
      lim_r     <= 16'd100;
      tol_r     <= 31'd66;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIM_COUNT: ndim_r    <= cfg_data[2:0];
        REG_SIZE_0:    size_r[0] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_1:    size_r[1] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_2:    size_r[2] <= cfg_data[SIZE_W-1:0];
        REG_SIZE_3:    size_r[3] <= cfg_data[SIZE_W-1:0];
        REG_ITER_LIM:  lim_r     <= cfg_data[15:0];
        REG_TOL:       tol_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared rounding divider
  rbgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quo)
  );

  // memories: one write and one read address a cycle, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      pmem[wa] <= wp;
      rmem[wa] <= wr;
      omem[wa] <= wo;
    end
    p_q <= pmem[rd_addr];
    r_q <= rmem[rd_addr];
    o_q <= omem[rd_addr];
  end

  // datapath helpers
  always_comb begin
    idx_ext  = 32'(in_data.cell_index);
    idx_ok   = idx_ext < 32'(MAX_CELLS);
    tot_prod = PW'(total_r) * PW'(sz[k_r]);
    st_prod  = PW'(st_r) * PW'(sz[k_r]);
    par = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) par = par ^ coord_r[d][0];
    jd = j_r[2:1];
    if (j_r[0]) begin
      nb_ok   = ({1'b0, jd} < nd_eff) && ((SIZE_W'(coord_r[jd]) + SIZE_W'(1)) < sz[jd]);
      nb_addr = c_r + stride_r[jd][AW-1:0];
    end else begin
      nb_ok   = ({1'b0, jd} < nd_eff) && (coord_r[jd] != '0);
      nb_addr = c_r - stride_r[jd][AW-1:0];
    end
    xv   = (SUM_W+1)'(sum_r) - (SUM_W+1)'(rc_r);
    xmag = xv[SUM_W] ? (SUM_W+1)'(-xv) : (SUM_W+1)'(xv);
    dvd  = DIV_W'(xmag) + DIV_W'(n_r >> 1);
    qs   = neg_r ? -(DIV_W+1)'(quo) : (DIV_W+1)'(quo);
    if (qs > (DIV_W+1)'(32'sh7fffffff))       qsat = 32'sh7fffffff;
    else if (qs < -(DIV_W+1)'(33'sh80000000)) qsat = 32'sh80000000;
    else                                      qsat = qs[31:0];
    rv   = RES_W'(np_r) - RES_W'(sum_r) + RES_W'(rc_r);
    rmag = rv[RES_W-1] ? RES_W'(-rv) : RES_W'(rv);
    last_cell = (TW'(c_r) == total_r - TW'(1));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    total_nxt = total_r;
    st_nxt    = st_r;
    for (int d = 0; d < MAX_DIMS; d++) begin
      stride_nxt[d] = stride_r[d];
      coord_nxt[d]  = coord_r[d];
    end
    c_nxt     = c_r;
    color_nxt = color_r;
    res_nxt   = res_r;
    it_nxt    = it_r;
    chk_nxt   = chk_r;
    j_nxt     = j_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    pc_nxt    = pc_r;
    rc_nxt    = rc_r;
    np_nxt    = np_r;
    worst_nxt = worst_r;
    stat_nxt  = stat_r;
    neg_nxt   = neg_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    rd_addr   = c_r;
    we        = 1'b0;
    wa        = c_r;
    wp        = qsat;
    wr        = rc_r;
    wo        = 1'b0;
    div_go    = 1'b0;
    carry     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = idx_ext[AW-1:0];
        if (start) begin
          unique case (cmd_t'(in_data.command))
            CMD_LOAD: begin
              we = idx_ok;
              wa = idx_ext[AW-1:0];
              wp = in_data.initial_pressure;
              wr = in_data.rhs_value;
              wo = in_data.is_obstacle;
            end
            CMD_SOLVE: begin
              k_nxt     = 2'd0;
              total_nxt = TW'(1);
              state_nxt = S_TOT;
            end
            CMD_READ: begin
              neg_nxt   = idx_ok;
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ov_nxt = 1'b1;
        od_nxt.result_kind    = KIND_READ;
        od_nxt.pressure_value = neg_r ? p_q : 32'sd0;
        od_nxt.iterations_run = '0;
        od_nxt.solve_status   = '0;
        state_nxt = S_RDOUT;
      end
      S_RDOUT: state_nxt = S_IDLE;
      S_TOT: begin
        if (tot_prod > PW'(MAX_CELLS)) begin
          it_nxt    = '0;
          stat_nxt  = ST_TOO_BIG;
          state_nxt = S_REP;
        end else begin
          total_nxt = TW'(tot_prod);
          if (k_r == nd_m1) begin
            st_nxt    = TW'(1);
            state_nxt = S_STR;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_STR: begin
        stride_nxt[k_r] = st_r;
        st_nxt = TW'(st_prod);
        if (k_r == 2'd0) begin
          for (int d = 0; d < MAX_DIMS; d++) coord_nxt[d] = '0;
          c_nxt     = '0;
          color_nxt = 1'b0;
          res_nxt   = 1'b0;
          it_nxt    = '0;
          chk_nxt   = '0;
          if (lim_r == '0) begin
            stat_nxt  = ST_LIMIT;
            state_nxt = S_REP;
          end else begin
            state_nxt = S_SWEEP;
          end
        end else begin
          k_nxt = k_r - 2'd1;
        end
      end
      S_SWEEP: begin
        rd_addr   = c_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (o_q || (!res_r && (par != color_r))) begin
          state_nxt = S_NEXT;
        end else begin
          pc_nxt    = p_q;
          rc_nxt    = r_q;
          sum_nxt   = '0;
          n_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        rd_addr = nb_addr;
        if (nb_ok) begin
          state_nxt = S_NBACC;
        end else if (j_r == 3'd7) begin
          state_nxt = S_CALC;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_NBACC: begin
        if (!o_q) begin
          sum_nxt = sum_r + SUM_W'(p_q);
          n_nxt   = n_r + CNT_W'(1);
        end
        if (j_r == 3'd7) state_nxt = S_CALC;
        else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = S_NB;
        end
      end
      S_CALC: begin
        if (res_r) begin
          np_nxt    = $signed({1'b0, n_r}) * pc_r;
          state_nxt = S_RES2;
        end else if (n_r == '0) begin
          state_nxt = S_NEXT;
        end else begin
          neg_nxt   = xv[SUM_W];
          div_go    = 1'b1;
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          we        = 1'b1;
          wa        = c_r;
          wp        = qsat;
          wr        = rc_r;
          wo        = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_RES2: begin
        if (rmag > worst_r) worst_nxt = rmag;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (!last_cell) begin
          // advance the flat index and the coordinate odometer
          c_nxt = c_r + AW'(1);
          for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            if (carry && (3'(d) < nd_eff)) begin
              if ((SIZE_W'(coord_r[d]) + SIZE_W'(1)) == sz[d]) begin
                coord_nxt[d] = '0;
              end else begin
                coord_nxt[d] = coord_r[d] + COORD_W'(1);
                carry = 1'b0;
              end
            end
          end
          state_nxt = S_SWEEP;
        end else begin
          c_nxt = '0;
          for (int d = 0; d < MAX_DIMS; d++) coord_nxt[d] = '0;
          state_nxt = S_SWEEP;
          if (res_r) begin
            res_nxt   = 1'b0;
            color_nxt = 1'b0;
            if (RES_W'(worst_r) < RES_W'(tol_r)) begin
              stat_nxt  = ST_CONVERGED;
              state_nxt = S_REP;
            end else if (it_r == lim_r) begin
              stat_nxt  = ST_LIMIT;
              state_nxt = S_REP;
            end
          end else if (!color_r) begin
            color_nxt = 1'b1;
          end else begin
            color_nxt = 1'b0;
            it_nxt    = it_r + 16'd1;
            if (chk_r == 4'(CHECK_PERIOD - 1)) begin
              chk_nxt   = '0;
              res_nxt   = 1'b1;
              worst_nxt = '0;
            end else begin
              chk_nxt = chk_r + 4'd1;
              if ((it_r + 16'd1) == lim_r) begin
                stat_nxt  = ST_LIMIT;
                state_nxt = S_REP;
              end
            end
          end
        end
      end
      S_REP: begin
        ov_nxt = 1'b1;
        od_nxt.result_kind    = KIND_SOLVE;
        od_nxt.pressure_value = 32'sd0;
        od_nxt.iterations_run = it_r;
        od_nxt.solve_status   = stat_r;
        state_nxt = S_RDOUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      it_r    <= it_nxt;
    end
    k_r     <= k_nxt;
    total_r <= total_nxt;
    st_r    <= st_nxt;
    for (int d = 0; d < MAX_DIMS; d++) begin
      stride_r[d] <= stride_nxt[d];
      coord_r[d]  <= coord_nxt[d];
    end
    c_r     <= c_nxt;
    color_r <= color_nxt;
    res_r   <= res_nxt;
    chk_r   <= chk_nxt;
    j_r     <= j_nxt;
    sum_r   <= sum_nxt;
    n_r     <= n_nxt;
    pc_r    <= pc_nxt;
    rc_r    <= rc_nxt;
    np_r    <= np_nxt;
    worst_r <= worst_nxt;
    stat_r  <= stat_nxt;
    neg_r   <= neg_nxt;
    od_r    <= od_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ----- test/rbgs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_checker: result predictor and scoreboard for the pressure solver
// Watches the command, result and register ports, keeps its own copy of the
// cell stores and registers, predicts every read answer and solve report and
// compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module rbgs_checker
  import rbgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int CELLS = 4096;

  // shadow cell stores; never-written entries stay zero
  logic signed [31:0] pres_mem [CELLS];
  logic signed [31:0] rhs_mem  [CELLS];
  logic               obst_mem [CELLS];

  // shadow registers
  logic [2:0]  dim_cnt;
  logic [12:0] dsize [MAX_DIMS];
  logic [15:0] iter_lim;
  logic [30:0] tol;

  // grid geometry of the running solve
  int nd_eff;
  longint gsize  [MAX_DIMS];
  longint stride [MAX_DIMS];

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  initial begin
    errors = 0;
    for (int i = 0; i < CELLS; i++) begin
      pres_mem[i] = '0;
      rhs_mem[i]  = '0;
      obst_mem[i] = 1'b0;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round to nearest, ties away from zero, then saturate
  function automatic logic signed [31:0] round_div(longint x, int n);
    longint mag;
    longint q;
    mag = (x < 0) ? -x : x;
    q = (mag + n / 2) / n;
    if (x < 0) q = -q;
    return clamp32(q);
  endfunction

  // sum and count of usable neighbors of cell c
  task automatic gather(longint c, output longint s, output int n);
    longint coord;
    s = 0;
    n = 0;
    for (int d = 0; d < nd_eff; d++) begin
      coord = (c / stride[d]) % gsize[d];
      if (coord > 0 && !obst_mem[c - stride[d]]) begin
        s += pres_mem[c - stride[d]];
        n++;
      end
      if (coord + 1 < gsize[d] && !obst_mem[c + stride[d]]) begin
        s += pres_mem[c + stride[d]];
        n++;
      end
    end
  endtask

  task automatic predict_solve(output logic [15:0] iters, output status_t st);
    longint total;
    longint acc;
    longint par;
    longint s;
    longint r;
    longint worst;
    int n;
    int done;
    bit too_big;
    nd_eff = (dim_cnt < 1) ? 1 : (dim_cnt > MAX_DIMS) ? MAX_DIMS : int'(dim_cnt);
    total = 1;
    too_big = 0;
    for (int d = 0; d < nd_eff; d++) begin
      gsize[d] = (dsize[d] == 0) ? 1 : longint'(dsize[d]);
      total *= gsize[d];
      if (total > CELLS) too_big = 1;
    end
    if (too_big) begin
      iters = '0;
      st = ST_TOO_BIG;
      return;
    end
    acc = 1;
    for (int k = nd_eff - 1; k >= 0; k--) begin
      stride[k] = acc;
      acc *= gsize[k];
    end
    done = 0;
    st = ST_LIMIT;
    for (int it = 0; it < iter_lim; it++) begin
      // even-parity sweep, then odd-parity sweep
      for (int color = 0; color < 2; color++) begin
        for (longint c = 0; c < total; c++) begin
          if (obst_mem[c]) continue;
          par = 0;
          for (int d = 0; d < nd_eff; d++) par += (c / stride[d]) % gsize[d];
          if ((par & 1) != color) continue;
          gather(c, s, n);
          if (n > 0) pres_mem[c] = round_div(s - longint'(rhs_mem[c]), n);
        end
      end
      done = it + 1;
      // periodic residual check
      if (done % CHECK_PERIOD == 0) begin
        worst = 0;
        for (longint c = 0; c < total; c++) begin
          if (obst_mem[c]) continue;
          gather(c, s, n);
          r = longint'(n) * longint'(pres_mem[c]) - s + longint'(rhs_mem[c]);
          if (r < 0) r = -r;
          if (r > worst) worst = r;
        end
        if (worst < longint'(tol)) begin
          st = ST_CONVERGED;
          break;
        end
      end
    end
    iters = done[15:0];
  endtask

  // channel monitor: inputs and outputs sampled at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    logic [15:0] its;
    status_t st;
    if (!rst_n) begin
      dim_cnt  <= 3'd2;
      dsize[0] <= 13'd64;
      dsize[1] <= 13'd64;
      dsize[2] <= 13'd1;
      dsize[3] <= 13'd1;
      iter_lim <= 16'd100;
      tol      <= 31'd66;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_DIM_COUNT: dim_cnt  <= cfg_data[2:0];
          REG_SIZE_0:    dsize[0] <= cfg_data[12:0];
          REG_SIZE_1:    dsize[1] <= cfg_data[12:0];
          REG_SIZE_2:    dsize[2] <= cfg_data[12:0];
          REG_SIZE_3:    dsize[3] <= cfg_data[12:0];
          REG_ITER_LIM:  iter_lim <= cfg_data[15:0];
          REG_TOL:       tol      <= cfg_data;
          default: ;
        endcase
      end
      // command transfer
      if (start && !busy) begin
        case (cmd_t'(in_data.command))
          CMD_LOAD: begin
            rhs_mem[in_data.cell_index]  = in_data.rhs_value;
            pres_mem[in_data.cell_index] = in_data.initial_pressure;
            obst_mem[in_data.cell_index] = in_data.is_obstacle;
          end
          CMD_SOLVE: begin
            predict_solve(its, st);
            want = '{result_kind: KIND_SOLVE, pressure_value: '0,
                     iterations_run: its, solve_status: st};
            expected_results.push_back(want);
          end
          CMD_READ: begin
            want = '{result_kind: KIND_READ, pressure_value: pres_mem[in_data.cell_index],
                     iterations_run: '0, solve_status: '0};
            expected_results.push_back(want);
          end
          default: ;
        endcase
      end
      // result transfer
      if (out_valid) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          report("unexpected result, kind", got.result_kind, -1);
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind)
            report("result_kind", got.result_kind, want.result_kind);
          if (got.pressure_value !== want.pressure_value)
            report("pressure_value", got.pressure_value, want.pressure_value);
          if (got.iterations_run !== want.iterations_run)
            report("iterations_run", got.iterations_run, want.iterations_run);
          if (got.solve_status !== want.solve_status)
            report("solve_status", got.solve_status, want.solve_status);
        end
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the red-black pressure solver
// Directed corner cases, then random grid setups: each that fits fills the whole
// grid, then mixes reads, solves, stray loads and ignored commands under varying
// sender idling. The checker module does prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import rbgs_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int STALL_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  int          errors;
  int          pending;

  int idle_pct;
  int n_load, n_read, n_solve, n_ignored, n_settings, n_random;
  int stall_cnt;
  bit written [4096];
  int written_list[$];

  always #1 clk = ~clk;

  red_black_gauss_seidel_pressure_top dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  rbgs_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout waiting for a transfer");
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // one command transfer; start is left high after it
  task automatic send(cmd_t c, int idx, logic signed [31:0] r, logic signed [31:0] p,
                      logic ob);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = '{command: c, cell_index: idx[11:0], rhs_value: r,
                initial_pressure: p, is_obstacle: ob};
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (c)
      CMD_LOAD: begin
        n_load++;
        if (!written[idx]) begin
          written[idx] = 1'b1;
          written_list.push_back(idx);
        end
      end
      CMD_SOLVE: n_solve++;
      CMD_READ:  n_read++;
      default:   n_ignored++;
    endcase
  endtask

  // idle the sender until every result is in
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_cfg(int nd, int s0, int s1, int s2, int s3, int lim, int tol);
    int vals[7];
    vals = '{nd, s0, s1, s2, s3, lim, tol};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[2:0];
      cfg_data = vals[i][30:0];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: case ($urandom_range(0, 3))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return 0;
           default: return -1;
         endcase
      default: return $signed($urandom) >>> 8;
    endcase
  endfunction

  // one random setting followed by a fill of its grid and mixed commands, or by solves only for an oversized grid
  task automatic random_frame(int phase);
    int nd, eff, cap, prod, total, ops, pick, idx;
    int sz[4];
    int lim, tol;
    bit huge;
    idle_pct = (phase % 4 == 1) ? 64 : (phase % 4 == 3) ? 32 : 0;
    nd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    eff = (nd < 1) ? 1 : (nd > 4) ? 4 : nd;
    huge = ($urandom_range(0, 11) == 0);
    cap = ($urandom_range(0, 3) == 0) ? 16 : 8;
    prod = 1;
    for (int d = 0; d < 4; d++) begin
      if (d < eff && !huge) begin
        sz[d] = $urandom_range(1, cap / prod);
        prod *= sz[d];
        if (sz[d] == 1 && $urandom_range(0, 2) == 0) sz[d] = 0;
      end else begin
        sz[d] = $urandom_range(0, 8191);
      end
    end
    if (huge) begin
      // oversized grid: only the first two sizes matter for the overflow
      if (eff < 2) nd = 2;
      sz[0] = $urandom_range(2, 4096);
      sz[1] = 4096 / sz[0] + 1 + $urandom_range(0, 50);
      prod = 4097;
    end
    lim = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 25);
    case ($urandom_range(0, 3))
      0: tol = 0;
      1: tol = $urandom_range(0, 1 << 18);
      2: tol = $urandom_range(0, 255);
      default: tol = $urandom & 32'h7fffffff;
    endcase
    set_cfg(nd, sz[0], sz[1], sz[2], sz[3], lim, tol);
    total = prod;
    if (huge) begin
      repeat (3) send(CMD_SOLVE, $urandom_range(0, 4095), rand_val(), rand_val(),
                      1'($urandom));
      n_random += 3;
      return;
    end
    for (int c = 0; c < total; c++) begin
      send(CMD_LOAD, c, rand_val(), rand_val(), $urandom_range(0, 5) == 0);
      n_random++;
    end
    ops = $urandom_range(10, 30);
    for (int k = 0; k < ops; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        idx = ($urandom_range(0, 4) == 0) ?
              written_list[$urandom_range(0, written_list.size() - 1)] :
              $urandom_range(0, total - 1);
        send(CMD_READ, idx, rand_val(), rand_val(), 1'($urandom));
      end else if (pick < 65) begin
        idx = ($urandom_range(0, 4) < 3) ? $urandom_range(0, total - 1)
                                           : $urandom_range(0, 4095);
        send(CMD_LOAD, idx, rand_val(), rand_val(), $urandom_range(0, 5) == 0);
      end else if (pick < 80) begin
        send(CMD_SOLVE, $urandom_range(0, 4095), rand_val(), rand_val(), 1'($urandom));
      end else if (pick < 88) begin
        send(CMD_NONE, $urandom_range(0, 4095), rand_val(), rand_val(), 1'($urandom));
        continue;
      end else begin
        send(CMD_READ, $urandom_range(0, total - 1), rand_val(), rand_val(),
             1'($urandom));
      end
      n_random++;
    end
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: 2x3 grid with extreme values and one obstacle
    set_cfg(2, 2, 3, 0, 8191, 20, 66);
    send(CMD_LOAD, 0, 32'sh7fffffff, 32'sh80000000, 1'b0);
    send(CMD_LOAD, 1, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send(CMD_LOAD, 2, 32'sh00010000, -32'sh00020000, 1'b1);
    send(CMD_LOAD, 3, -32'sd5, 32'sh00008000, 1'b0);
    send(CMD_LOAD, 4, 32'sd3, -32'sh00000001, 1'b0);
    send(CMD_LOAD, 5, 32'sd0, 32'sh00030000, 1'b0);
    send(CMD_LOAD, 4095, 32'sh55555555, 32'shaaaaaaaa, 1'b1);
    send(CMD_READ, 0, 0, 0, 1'b0);
    send(CMD_READ, 4095, 0, 0, 1'b0);
    send(CMD_NONE, 1, 0, 0, 1'b0);
    send(CMD_SOLVE, 0, 0, 0, 1'b0);
    send(CMD_READ, 1, 0, 0, 1'b0);
    send(CMD_READ, 2, 0, 0, 1'b0);
    // single isolated cell, count 0 acting as one dimension, zero iteration limit
    set_cfg(0, 1, 5, 5, 5, 0, 66);
    send(CMD_SOLVE, 0, 0, 0, 1'b0);
    set_cfg(0, 1, 5, 5, 5, 12, 32'h7fffffff);
    send(CMD_SOLVE, 0, 0, 0, 1'b0);
    send(CMD_READ, 0, 0, 0, 1'b0);
    // count above four, zero sizes acting as one, tolerance zero never converges
    set_cfg(7, 0, 2, 0, 2, 10, 0);
    send(CMD_SOLVE, 0, 0, 0, 1'b0);
    send(CMD_READ, 3, 0, 0, 1'b0);
    // oversized grid with all sizes at 4096
    set_cfg(2, 4096, 4096, 4096, 4096, 65535, 66);
    send(CMD_SOLVE, 0, 0, 0, 1'b0);

    // random part
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      random_frame(phase);
      phase++;
    end

    drain();
    repeat (40) @(negedge clk);
    $display("covered %0d loads, %0d reads, %0d solves and %0d ignored commands",
             n_load, n_read, n_solve, n_ignored);
    $display("across %0d register settings with varied sender idling", n_settings);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rbgs_pkg.sv
hdl/rbgs_div.sv
hdl/red_black_gauss_seidel_pressure_top.sv
test/rbgs_checker.sv
test/testbench.sv
